[rtl/tpat_pkg.sv]
// ----------------------------------------------------------------------------
// tpat_pkg
// Shared constants, request codes and types for the tag presence aging table.
// ----------------------------------------------------------------------------
package tpat_pkg;

	localparam int MAX_TAGS      = 16;
	localparam int UID_BYTES     = 10;
	localparam int UID_W         = 8 * UID_BYTES;
	localparam int IDX_W         = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int CNT_W         = $clog2(MAX_TAGS + 1);
	localparam logic [7:0] TIMEOUT_RESET = 8'd5;

	// request codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_CARD = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// event kinds
	localparam logic EVT_HOME = 1'b0;
	localparam logic EVT_AWAY = 1'b1;

	typedef struct packed {
		logic [63:0] uid_low;
		logic [15:0] uid_high;
		logic [3:0]  uid_len;
		logic [7:0]  count;
	} tpat_entry_t;

endpackage

[rtl/tag_presence_aging_table.sv]
// ----------------------------------------------------------------------------
// tag_presence_aging_table
// Table of known tag identifiers with per-entry presence countdown; card
// sightings raise home events, ticks raise away events, in entry order.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+------------------
//  request  | req_type entry_index uid_* ...   | in        | in_valid/in_stall
//  event    | event_entry event_kind last      | out       | out_valid/out_stall
//  config   | cfg_data (timeout_ticks)         | in        | cfg_valid/cfg_ready
//
//  load and unknown requests leave the block ready again in the following
//  cycle; the table is written in the cycle the request is taken.
//  card and tick requests walk the entry memory one entry per cycle unless
//  the walk is held; the next request is taken only after the registered
//  read of the single read port and the drain and flush of the last event.
//  out_stall held with an event waiting holds the walk at that entry.
//  reset clears the in-use bits and sets timeout_ticks to 5; no clearing pass.
// ----------------------------------------------------------------------------
module tag_presence_aging_table
	import tpat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  entry_index,
	input  logic [63:0] uid_low,
	input  logic [15:0] uid_high,
	input  logic [3:0]  uid_len,
	input  logic        entry_valid,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_entry,
	output logic        event_kind,
	output logic        last,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]          state_q;
	logic [7:0]          timeout_q;
	logic [MAX_TAGS-1:0] in_use_q;

	// request held for the walk
	logic [1:0]          req_q;
	logic [UID_W-1:0]    uid_q;
	logic [3:0]          len_q;

	// entry memory
	tpat_entry_t         mem [MAX_TAGS];
	tpat_entry_t         rd_data_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	tpat_entry_t         wr_data;

	logic [CNT_W-1:0]    rd_cnt_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                pend_v_q;
	logic [IDX_W-1:0]    pend_entry_q;
	logic                pend_kind_q;

	logic                out_v_q;
	logic [3:0]          out_entry_q;
	logic                out_kind_q;
	logic                out_last_q;

	logic                accept;
	logic [3:0]          len_clamp;
	logic                load_acc;
	logic                out_free;
	logic                walk_stall;
	logic                issuing;
	logic                proc;
	logic                hit;
	logic                dec;
	logic                upd;
	logic                evt;
	logic                evt_kind;
	logic [7:0]          new_count;
	logic                flush_out;
	logic                out_load;

	function automatic logic uid_match(input logic [UID_W-1:0] a,
			input logic [UID_W-1:0] b, input logic [3:0] n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < UID_BYTES; i++) begin
			if ((4'(i) < n) && (a[8*i +: 8] != b[8*i +: 8])) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign len_clamp = (uid_len > 4'(UID_BYTES)) ? 4'(UID_BYTES) : uid_len;
	assign load_acc  = accept && (req_type == REQ_LOAD) && (int'(entry_index) < MAX_TAGS);

	assign out_free   = !out_v_q || !out_stall;
	assign walk_stall = v_s1 && pend_v_q && !out_free;
	assign issuing    = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(MAX_TAGS)) && !walk_stall;
	assign proc       = v_s1 && !walk_stall;
	assign rd_addr    = walk_stall ? idx_s1 : rd_cnt_q[IDX_W-1:0];

	// entry update for the entry arriving from memory
	always_comb begin
		logic [3:0] n;
		n         = (rd_data_q.uid_len < len_q) ? rd_data_q.uid_len : len_q;
		hit       = 1'b0;
		dec       = 1'b0;
		evt       = 1'b0;
		evt_kind  = EVT_HOME;
		new_count = rd_data_q.count;
		case (req_q)
			REQ_CARD: begin
				hit = in_use_q[idx_s1] &&
					uid_match({rd_data_q.uid_high, rd_data_q.uid_low}, uid_q, n);
				evt       = hit && (rd_data_q.count == 8'd0);
				evt_kind  = EVT_HOME;
				new_count = timeout_q;
			end
			REQ_TICK: begin
				dec       = in_use_q[idx_s1] && (rd_data_q.count != 8'd0);
				new_count = rd_data_q.count - 8'd1;
				evt       = dec && (new_count == 8'd0);
				evt_kind  = EVT_AWAY;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign upd = proc && (hit || dec);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_q;
		if (load_acc) begin
			wr_en            = 1'b1;
			wr_addr          = IDX_W'(entry_index);
			wr_data.uid_low  = uid_low;
			wr_data.uid_high = uid_high;
			wr_data.uid_len  = len_clamp;
			wr_data.count    = entry_valid ? timeout_q : 8'd0;
		end else if (upd) begin
			wr_en         = 1'b1;
			wr_data.count = new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign flush_out = (state_q == ST_FLUSH) && pend_v_q && out_free;
	assign out_load  = (proc && evt && pend_v_q) || flush_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			timeout_q <= TIMEOUT_RESET;
			in_use_q  <= '0;
			rd_cnt_q  <= '0;
			v_s1      <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (load_acc) begin
				in_use_q[IDX_W'(entry_index)] <= entry_valid;
			end

			if (issuing) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				v_s1     <= 1'b1;
			end else if (!walk_stall) begin
				v_s1 <= 1'b0;
			end

			// new event pushes the waiting one out; last is known only at the end
			if (proc && evt) begin
				pend_v_q <= 1'b1;
			end else if (flush_out) begin
				pend_v_q <= 1'b0;
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && ((req_type == REQ_CARD) || (req_type == REQ_TICK))) begin
						state_q  <= ST_WALK;
						rd_cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if ((rd_cnt_q == CNT_W'(MAX_TAGS)) && !v_s1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			uid_q <= {uid_high, uid_low};
			len_q <= len_clamp;
		end
		if (issuing) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (proc && evt) begin
			pend_entry_q <= idx_s1;
			pend_kind_q  <= evt_kind;
		end
		if (out_load) begin
			out_entry_q <= 4'(pend_entry_q);
			out_kind_q  <= pend_kind_q;
			out_last_q  <= flush_out;
		end
	end

	assign out_valid   = out_v_q;
	assign event_entry = out_entry_q;
	assign event_kind  = out_kind_q;
	assign last        = out_last_q;

endmodule

[rtl/tpat_checker.sv]
// ----------------------------------------------------------------------------
// tpat_checker
// Port-level checks on the tag presence aging table.
// ----------------------------------------------------------------------------
module tpat_checker
	import tpat_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  event_entry,
	input logic        event_kind,
	input logic        last,
	input logic        cfg_ready
);

	// config is taken exactly when requests are
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("cfg_ready and in_stall disagree");

	// after a load or unknown request the block takes requests again in the next cycle
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((req_type == REQ_LOAD) || (req_type == REQ_NONE))
		|=> !in_stall)
		else $error("block busy after a load request");

	// card and tick requests start a table walk
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((req_type == REQ_CARD) || (req_type == REQ_TICK))
		|=> in_stall)
		else $error("no walk after card or tick request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_entry)
		&& $stable(event_kind) && $stable(last))
		else $error("stalled event changed");

endmodule

bind tag_presence_aging_table tpat_checker u_tpat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.req_type    (req_type),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_entry (event_entry),
	.event_kind  (event_kind),
	.last        (last),
	.cfg_ready   (cfg_ready)
);

[test/presence_event_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// presence_event_checker
// Watches the request, event and configuration channels of the tag presence
// aging table, keeps its own copy of the table and compares every event.
// ----------------------------------------------------------------------------
module presence_event_checker
	import tpat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  entry_index,
	input  logic [63:0] uid_low,
	input  logic [15:0] uid_high,
	input  logic [3:0]  uid_len,
	input  logic        entry_valid,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  event_entry,
	input  logic        event_kind,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          error_count,
	output int          events_pending
);

	typedef struct packed {
		logic [3:0] entry;
		logic       kind;
		logic       last;
	} presence_event_t;

	logic [UID_W-1:0] tag_uid [MAX_TAGS];
	logic [3:0]       tag_len [MAX_TAGS];
	logic             tag_live [MAX_TAGS];
	logic [7:0]       tag_countdown [MAX_TAGS];
	logic [7:0]       reload_ticks;
	presence_event_t  expected_events [$];

	initial error_count = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	// updates the table for one request and queues the events it causes
	function automatic void predict_events(input logic [1:0] kind, input logic [3:0] idx,
			input logic [UID_W-1:0] uid, input logic [3:0] len_in, input logic live);
		logic [3:0] len;
		logic [3:0] span;
		logic hit;
		int first;
		presence_event_t ev;
		len = (len_in > UID_BYTES) ? 4'(UID_BYTES) : len_in;
		first = expected_events.size();
		case (kind)
		REQ_LOAD: begin
			if (idx < MAX_TAGS) begin
				tag_uid[idx] = uid;
				tag_len[idx] = len;
				tag_live[idx] = live;
				tag_countdown[idx] = live ? reload_ticks : 8'd0;
			end
		end
		REQ_CARD: begin
			for (int e = 0; e < MAX_TAGS; e++) begin
				hit = tag_live[e];
				span = (tag_len[e] < len) ? tag_len[e] : len;
				for (int i = 0; i < span; i++)
					if (tag_uid[e][8*i +: 8] != uid[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					if (tag_countdown[e] == 8'd0) begin
						ev.entry = 4'(e);
						ev.kind = EVT_HOME;
						ev.last = 1'b0;
						expected_events.push_back(ev);
					end
					tag_countdown[e] = reload_ticks;
				end
			end
		end
		REQ_TICK: begin
			for (int e = 0; e < MAX_TAGS; e++) begin
				if (tag_live[e] && tag_countdown[e] != 8'd0) begin
					tag_countdown[e] = tag_countdown[e] - 8'd1;
					if (tag_countdown[e] == 8'd0) begin
						ev.entry = 4'(e);
						ev.kind = EVT_AWAY;
						ev.last = 1'b0;
						expected_events.push_back(ev);
					end
				end
			end
		end
		default: ;
		endcase
		if (expected_events.size() > first) begin
			ev = expected_events.pop_back();
			ev.last = 1'b1;
			expected_events.push_back(ev);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		presence_event_t want;
		if (!arst_n) begin
			for (int e = 0; e < MAX_TAGS; e++) begin
				tag_uid[e] = '0;
				tag_len[e] = '0;
				tag_live[e] = 1'b0;
				tag_countdown[e] = '0;
			end
			reload_ticks = TIMEOUT_RESET;
			expected_events.delete();
			events_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reload_ticks = cfg_data;
			if (in_valid && !in_stall)
				predict_events(req_type, entry_index, {uid_high, uid_low}, uid_len,
					entry_valid);
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("event with none expected: entry %0d kind %0d last %0d",
						event_entry, event_kind, last));
				end else begin
					want = expected_events.pop_front();
					if (event_entry !== want.entry)
						report_mismatch($sformatf("event_entry %0d, expected %0d",
							event_entry, want.entry));
					if (event_kind !== want.kind)
						report_mismatch($sformatf("event_kind %0d on entry %0d, expected %0d",
							event_kind, want.entry, want.kind));
					if (last !== want.last)
						report_mismatch($sformatf("last %0d on entry %0d, expected %0d",
							last, want.entry, want.last));
				end
			end
			events_pending <= expected_events.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, card and tick requests into the tag presence aging table under
// several timeout settings and idling patterns; the checker beside the block
// predicts and compares every presence event.
// ----------------------------------------------------------------------------
module testbench;
	import tpat_pkg::*;

	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_REQUESTS = 90;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [3:0]  entry_index;
	logic [63:0] uid_low;
	logic [15:0] uid_high;
	logic [3:0]  uid_len;
	logic        entry_valid;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  event_entry;
	logic        event_kind;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	int          error_count;
	int          events_pending;

	int send_idle_pct;
	int recv_stall_pct;
	bit holdoff_request;

	// identifiers last loaded, used to aim card requests at the table
	logic [UID_W-1:0] known_uid [MAX_TAGS];
	logic [3:0]       known_len [MAX_TAGS];

	tag_presence_aging_table i_dut (.*);

	presence_event_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_request) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_request = 1'b0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_request(input logic [1:0] kind, input logic [3:0] idx,
			input logic [UID_W-1:0] uid, input logic [3:0] len, input logic live);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		uid_low <= uid[63:0];
		uid_high <= uid[UID_W-1:64];
		uid_len <= len;
		entry_valid <= live;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		if (kind == REQ_LOAD) begin
			known_uid[idx] = uid;
			known_len[idx] = len;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (events_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] ticks);
		bit taken;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item(output bit counted);
		logic [UID_W-1:0] uid;
		logic [3:0] idx;
		logic [3:0] len;
		int pick;
		int b;
		pick = $urandom_range(99);
		idx = 4'($urandom_range(MAX_TAGS - 1));
		uid = UID_W'({$urandom, $urandom, $urandom});
		len = 4'($urandom_range(1, UID_BYTES));
		if ($urandom_range(9) == 0)
			len = 4'($urandom_range(15));
		counted = 1'b1;
		if (pick < 3) begin
			counted = 1'b0;
			send_request(REQ_NONE, idx, uid, len, 1'b1);
		end else if (pick < 25) begin
			send_request(REQ_LOAD, idx, uid, len, $urandom_range(9) != 0);
		end else if (pick < 60) begin
			// mostly a known tag, sometimes seen through another length or one bit off
			if ($urandom_range(3) != 0) begin
				uid = known_uid[idx];
				case ($urandom_range(3))
				0: len = 4'($urandom_range(15));
				1: begin
					b = $urandom_range(UID_BYTES - 1);
					uid[8*b +: 8] = uid[8*b +: 8] ^ 8'(1 << $urandom_range(7));
				end
				default: len = known_len[idx];
				endcase
			end
			send_request(REQ_CARD, idx, uid, len, 1'b0);
		end else begin
			send_request(REQ_TICK, idx, uid, len, 1'b0);
		end
	endtask

	initial begin
		logic [UID_W-1:0] uid;
		logic [3:0] len;
		logic [7:0] phase_ticks [5];
		int sent;
		bit counted;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		entry_index = '0;
		uid_low = '0;
		uid_high = '0;
		uid_len = '0;
		entry_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_request = 1'b0;
		phase_ticks = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3};
		for (int e = 0; e < MAX_TAGS; e++) begin
			known_uid[e] = UID_W'({$urandom, $urandom, $urandom});
			known_len[e] = 4'($urandom_range(UID_BYTES));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// card on an empty table gives nothing
		send_request(REQ_CARD, 4'd0, '1, 4'd10, 1'b0);
		// fill every entry: all-ones, all-zero, a zero length, an over-long length
		for (int e = 0; e < MAX_TAGS; e++) begin
			uid = UID_W'({$urandom, $urandom, $urandom});
			len = 4'(e % (UID_BYTES + 1));
			if (e == 0) begin
				uid = '1;
				len = 4'd10;
			end
			if (e == MAX_TAGS - 1)
				uid = '0;
			if (e == 3)
				len = 4'd15;
			send_request(REQ_LOAD, 4'(e), uid, len, 1'b1);
		end
		send_request(REQ_NONE, 4'd9, '1, 4'd15, 1'b1);
		// zero length matches everything: all reloaded, then all time out together
		send_request(REQ_CARD, 4'd0, UID_W'({$urandom, $urandom, $urandom}), 4'd0, 1'b0);
		repeat (5) send_request(REQ_TICK, 4'd15, '1, 4'd15, 1'b1);
		send_request(REQ_CARD, 4'd15, '0, 4'd0, 1'b0);
		send_request(REQ_LOAD, 4'd7, '1, 4'd10, 1'b0);
		send_request(REQ_CARD, 4'd0, '1, 4'd10, 1'b0);

		for (int phase = 0; phase < 5; phase++) begin
			write_timeout(phase_ticks[phase]);
			case (phase)
			1: begin send_idle_pct = 78; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 78; end
			3: begin send_idle_pct = 27; recv_stall_pct = 27; end
			default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				send_random_item(counted);
				if (counted) begin
					sent++;
					// receiver holds off while requests keep coming, later the sender pauses
					if (phase == 4 && sent == 30)
						holdoff_request = 1'b1;
					if (phase == 4 && sent == 60)
						wait_drained();
				end
			end
		end

		wait_drained();
		if (error_count == 0 && events_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[tag_presence_aging_table.f]
rtl/tpat_pkg.sv
rtl/tag_presence_aging_table.sv
rtl/tpat_checker.sv
test/presence_event_checker.sv
test/testbench.sv
